FILE: design/thread_slot_scheduler_core_macros.svh
`ifndef THREAD_SLOT_SCHEDULER_CORE_MACROS_SVH
`define THREAD_SLOT_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("thread slot scheduler check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thread slot scheduler check failed");

`endif

FILE: design/tss_pkg.sv
package tss_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned ID_W   = 4;
  localparam int unsigned PRIO_W = 8;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_YIELDED  = 2'd2,
    ST_SCHED    = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_YIELD    = 2'd2,
    CMD_DESTROY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ALG_FCFS = 2'd0,
    ALG_RR   = 2'd1,
    ALG_PRIO = 2'd2
  } alg_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_SLOT    = 2'd1,
    STATUS_NO_CURRENT = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] thread_id;
    logic [ID_W-1:0] current_id;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        state;
    logic [PRIO_W-1:0] prio;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_prio_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_entry;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       entry;
  } ram_rsp_t;

  typedef struct packed {
    logic              busy;
    logic              cur_valid;
    logic [SLOT_W-1:0] cur_slot;
  } ctrl_stat_t;

  // Low bits of a slot number as a thread id, zero-extended for small tables.
  function automatic logic [ID_W-1:0] to_id(input logic [SLOT_W-1:0] slot);
    logic [ID_W+SLOT_W-1:0] ext;
    ext = {{ID_W{1'b0}}, slot};
    return ext[ID_W-1:0];
  endfunction

endpackage

FILE: design/thread_slot_scheduler_core.sv
// Thread slot scheduler: a table of SLOTS thread slots (slot 0 is the scheduler)
// held in a synchronous slot RAM with one read and one write port. Create and
// schedule walk the whole table, one slot read per cycle, before their result
// is valid; a schedule that revives yielded slots (round robin with nothing
// runnable, or any priority schedule that finds a yielded slot) adds a second
// walk that writes them back as runnable. Yield, destroy and schedule with the
// unused algorithm code have their result valid in the cycle after the request
// is accepted. A new request is taken only when the previous one has finished;
// the finished result sits in an output register, so it may wait there while
// the next request is already at work. No clearing pass follows reset: per-slot
// valid bits make unwritten slots read as reset.
// The algorithm register is written whenever the configuration channel is
// valid; write it only while no request is in flight.
module thread_slot_scheduler_core import tss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

`include "thread_slot_scheduler_core_macros.svh"

  logic [1:0] alg_q;
  logic       out_valid_q;
  out_item_t  out_data_q;

  ram_req_t   ram_req;
  ram_rsp_t   ram_rsp;
  logic       res_valid;
  out_item_t  res;
  logic       res_ack;
  ctrl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q <= ALG_FCFS;
    end else if (cfg_valid_i) begin
      alg_q <= cfg_data_i;
    end
  end

  tss_slot_ram u_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ram_req),
    .rsp_o  (ram_rsp)
  );

  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alg_i       (alg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ram_req_o   (ram_req),
    .ram_rsp_i   (ram_rsp),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack),
    .stat_o      (stat)
  );

  // Load the output register when it is empty or being drained.
  assign res_ack = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TSS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o && stat.busy)
  `TSS_ASSERT_NEXT(a_idle_after_result, res_ack, in_ready_o)
  `TSS_ASSERT_NEXT(a_ram_read_returns, ram_req.rd_en, ram_rsp.valid)
  `TSS_ASSERT_IMPL(a_no_current_is_zero, !stat.cur_valid, stat.cur_slot == '0)

endmodule

FILE: design/tss_slot_ram.sv
module tss_slot_ram import tss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ram_req_t req_i,
  output ram_rsp_t rsp_o
);

  logic [1:0]        state_mem [SLOTS];
  logic [PRIO_W-1:0] prio_mem  [SLOTS];
  logic [SLOTS-1:0]  vld_q;

  logic [1:0]        rd_state_q;
  logic [PRIO_W-1:0] rd_prio_q;
  logic              rd_vld_q;
  logic              rd_valid_q;
  logic [SLOT_W-1:0] rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      state_mem[req_i.wr_addr] <= req_i.wr_entry.state;
      if (req_i.wr_prio_en) begin
        prio_mem[req_i.wr_addr] <= req_i.wr_entry.prio;
      end
    end
    if (req_i.rd_en) begin
      rd_state_q <= state_mem[req_i.rd_addr];
      rd_prio_q  <= prio_mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      rd_valid_q <= req_i.rd_en;
      if (req_i.rd_en) begin
        rd_vld_q  <= vld_q[req_i.rd_addr];
        rd_addr_q <= req_i.rd_addr;
      end
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  // Unwritten entries read as their reset value: slot 0 scheduler, others free.
  always_comb begin
    rsp_o.valid = rd_valid_q;
    rsp_o.addr  = rd_addr_q;
    if (rd_vld_q) begin
      rsp_o.entry.state = rd_state_q;
      rsp_o.entry.prio  = rd_prio_q;
    end else begin
      rsp_o.entry.state = (rd_addr_q == '0) ? ST_SCHED : ST_FREE;
      rsp_o.entry.prio  = '0;
    end
  end

endmodule

FILE: design/tss_ctrl.sv
module tss_ctrl import tss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] alg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output ram_req_t   ram_req_o,
  input  ram_rsp_t   ram_rsp_i,
  output logic       res_valid_o,
  output out_item_t  res_o,
  input  logic       res_ack_i,
  output ctrl_stat_t stat_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_REVIVE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

  logic [1:0]        st_q, st_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              free_have_q, free_have_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic              run_have_q, run_have_d;
  logic [SLOT_W-1:0] run_idx_q, run_idx_d;
  logic [PRIO_W-1:0] run_prio_q, run_prio_d;
  logic              yld_have_q, yld_have_d;
  logic [SLOT_W-1:0] yld_idx_q, yld_idx_d;
  logic [PRIO_W-1:0] yld_prio_q, yld_prio_d;

  logic              cur_valid_q, cur_valid_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  out_item_t         res_q, res_d;

  logic              pass_done;
  logic              is_prio;
  logic              pick_have;
  logic [SLOT_W-1:0] pick_idx;
  logic              revive;

  assign is_prio   = (alg_i == ALG_PRIO);
  assign pass_done = (cnt_q == CNT_END) && !ram_rsp_i.valid;

  // Nothing runnable: fall back to the yielded slots that get revived.
  assign pick_have = run_have_q || (yld_have_q && (alg_i != ALG_FCFS));
  assign pick_idx  = run_have_q ? run_idx_q : yld_idx_q;
  assign revive    = yld_have_q && (is_prio || ((alg_i == ALG_RR) && !run_have_q));

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    prio_d      = prio_q;
    cnt_d       = cnt_q;
    free_have_d = free_have_q;
    free_idx_d  = free_idx_q;
    run_have_d  = run_have_q;
    run_idx_d   = run_idx_q;
    run_prio_d  = run_prio_q;
    yld_have_d  = yld_have_q;
    yld_idx_d   = yld_idx_q;
    yld_prio_d  = yld_prio_q;
    cur_valid_d = cur_valid_q;
    cur_slot_d  = cur_slot_q;
    res_d       = res_q;

    ram_req_o            = '0;
    ram_req_o.rd_addr    = cnt_q[SLOT_W-1:0];
    ram_req_o.rd_en      = ((st_q == S_SCAN) || (st_q == S_REVIVE)) && (cnt_q != CNT_END);

    if (ram_req_o.rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = in_data_i.command;
          prio_d      = in_data_i.priority_req;
          cnt_d       = '0;
          free_have_d = 1'b0;
          run_have_d  = 1'b0;
          yld_have_d  = 1'b0;
          unique case (in_data_i.command)
            CMD_CREATE: begin
              st_d = S_SCAN;
            end
            CMD_SCHEDULE: begin
              if ((alg_i == ALG_FCFS) || (alg_i == ALG_RR) || is_prio) begin
                st_d = S_SCAN;
              end else begin
                res_d = '{status: STATUS_NO_SLOT, thread_id: '0,
                          current_id: to_id(cur_slot_q)};
                st_d  = S_DONE;
              end
            end
            default: begin
              if (!cur_valid_q) begin
                res_d = '{status: STATUS_NO_CURRENT, thread_id: '0, current_id: '0};
              end else begin
                // Hand the current thread back; priority stays as it was.
                ram_req_o.wr_en          = 1'b1;
                ram_req_o.wr_addr        = cur_slot_q;
                ram_req_o.wr_entry.state = (in_data_i.command == CMD_YIELD) ?
                                           ST_YIELDED : ST_FREE;
                res_d = '{status: STATUS_OK, thread_id: to_id(cur_slot_q),
                          current_id: '0};
                cur_valid_d = 1'b0;
                cur_slot_d  = '0;
              end
              st_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (ram_rsp_i.valid) begin
          if ((ram_rsp_i.entry.state == ST_FREE) && !free_have_q) begin
            free_have_d = 1'b1;
            free_idx_d  = ram_rsp_i.addr;
          end
          // Strict compare: the lowest slot wins a priority tie.
          if ((ram_rsp_i.entry.state == ST_RUNNABLE) &&
              (!run_have_q || (is_prio && (ram_rsp_i.entry.prio > run_prio_q)))) begin
            run_have_d = 1'b1;
            run_idx_d  = ram_rsp_i.addr;
            run_prio_d = ram_rsp_i.entry.prio;
          end
          if ((ram_rsp_i.entry.state == ST_YIELDED) &&
              (!yld_have_q || (is_prio && (ram_rsp_i.entry.prio > yld_prio_q)))) begin
            yld_have_d = 1'b1;
            yld_idx_d  = ram_rsp_i.addr;
            yld_prio_d = ram_rsp_i.entry.prio;
          end
        end
        if (pass_done) begin
          if (cmd_q == CMD_CREATE) begin
            if (free_have_q) begin
              ram_req_o.wr_en          = 1'b1;
              ram_req_o.wr_prio_en     = 1'b1;
              ram_req_o.wr_addr        = free_idx_q;
              ram_req_o.wr_entry.state = ST_RUNNABLE;
              ram_req_o.wr_entry.prio  = prio_q;
              res_d = '{status: STATUS_OK, thread_id: to_id(free_idx_q),
                        current_id: to_id(cur_slot_q)};
            end else begin
              res_d = '{status: STATUS_NO_SLOT, thread_id: '0,
                        current_id: to_id(cur_slot_q)};
            end
            st_d = S_DONE;
          end else begin
            if (pick_have) begin
              cur_valid_d = 1'b1;
              cur_slot_d  = pick_idx;
              res_d = '{status: STATUS_OK, thread_id: to_id(pick_idx),
                        current_id: to_id(pick_idx)};
            end else begin
              cur_valid_d = 1'b0;
              cur_slot_d  = '0;
              res_d = '{status: STATUS_NO_SLOT, thread_id: '0, current_id: '0};
            end
            cnt_d = '0;
            st_d  = revive ? S_REVIVE : S_DONE;
          end
        end
      end

      S_REVIVE: begin
        // Write back slot k while slot k+1 is read: never the same entry.
        if (ram_rsp_i.valid && (ram_rsp_i.entry.state == ST_YIELDED)) begin
          ram_req_o.wr_en          = 1'b1;
          ram_req_o.wr_addr        = ram_rsp_i.addr;
          ram_req_o.wr_entry.state = ST_RUNNABLE;
        end
        if (pass_done) begin
          st_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ack_i) begin
          st_d = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      free_have_q <= 1'b0;
      run_have_q  <= 1'b0;
      yld_have_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      free_have_q <= free_have_d;
      run_have_q  <= run_have_d;
      yld_have_q  <= yld_have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    prio_q     <= prio_d;
    free_idx_q <= free_idx_d;
    run_idx_q  <= run_idx_d;
    run_prio_q <= run_prio_d;
    yld_idx_q  <= yld_idx_d;
    yld_prio_q <= yld_prio_d;
    res_q      <= res_d;
  end

  assign in_ready_o       = (st_q == S_IDLE);
  assign res_valid_o      = (st_q == S_DONE);
  assign res_o            = res_q;
  assign stat_o.busy      = (st_q != S_IDLE);
  assign stat_o.cur_valid = cur_valid_q;
  assign stat_o.cur_slot  = cur_slot_q;

endmodule
